/* design/mck_pkg.sv */
// ---------------------------------------------------------------------------
// mck_pkg
// shared types, constants and the character code rom of the morse keyer
// ---------------------------------------------------------------------------
package mck_pkg;

    localparam int CHAR_W = 8;
    localparam int DUR_W  = 16;
    localparam int SYM_W  = 16;
    localparam int ADDR_W = 3;

    // register indexes on the configuration port
    localparam logic [ADDR_W-1:0] REG_DIT        = 3'd0;
    localparam logic [ADDR_W-1:0] REG_DAH        = 3'd1;
    localparam logic [ADDR_W-1:0] REG_ELEM_GAP   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_LETTER_GAP = 3'd3;
    localparam logic [ADDR_W-1:0] REG_WORD_GAP   = 3'd4;

    localparam logic [DUR_W-1:0] RST_DIT        = 16'd60;
    localparam logic [DUR_W-1:0] RST_DAH        = 16'd180;
    localparam logic [DUR_W-1:0] RST_ELEM_GAP   = 16'd60;
    localparam logic [DUR_W-1:0] RST_LETTER_GAP = 16'd180;
    localparam logic [DUR_W-1:0] RST_WORD_GAP   = 16'd420;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_FIRST = 8'd33;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'd126;

    // mask of the low bit of every element pair: set for dit and dah
    localparam logic [SYM_W-1:0] ELEM_MASK = 16'h5555;

    // duration source selects
    localparam logic [1:0] DUR_KEY  = 2'd0;
    localparam logic [1:0] DUR_EGAP = 2'd1;
    localparam logic [1:0] DUR_GAP  = 2'd2;
    localparam logic [1:0] DUR_ZERO = 2'd3;

    localparam int ROM_DEPTH = 94;

    localparam logic [SYM_W-1:0] CODE_ROM [0:ROM_DEPTH-1] = '{
        16'hDDF0, 16'h75D0, 16'h0000, 16'h575C, 16'h0000, 16'h7540, 16'h7FD0,
        16'hDF40, 16'hDF70, 16'h0000, 16'h7740, 16'hF5F0, 16'hD570, 16'h7770,
        16'hD740,
        16'hFFC0, 16'h7FC0, 16'h5FC0, 16'h57C0, 16'h55C0, 16'h5540, 16'hD540,
        16'hF540, 16'hFD40, 16'hFF40,
        16'hFD50, 16'hDDD0, 16'h0000, 16'hD5C0, 16'h0000, 16'h5F50, 16'h7DD0,
        16'h7000, 16'hD500, 16'hDD00, 16'hD400, 16'h4000, 16'h5D00, 16'hF400,
        16'h5500, 16'h5000, 16'h7F00, 16'hDC00, 16'h7500, 16'hF000, 16'hD000,
        16'hFC00, 16'h7D00, 16'hF700, 16'h7400, 16'h5400, 16'hC000, 16'h5C00,
        16'h5700, 16'h7C00, 16'hD700, 16'hDF00, 16'hF500,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h5F70, 16'h0000,
        16'h7000, 16'hD500, 16'hDD00, 16'hD400, 16'h4000, 16'h5D00, 16'hF400,
        16'h5500, 16'h5000, 16'h7F00, 16'hDC00, 16'h7500, 16'hF000, 16'hD000,
        16'hFC00, 16'h7D00, 16'hF700, 16'h7400, 16'h5400, 16'hC000, 16'h5C00,
        16'h5700, 16'h7C00, 16'hD700, 16'hDF00, 16'hF500,
        16'h0000, 16'h0000, 16'h0000, 16'h0000
    };

    // element pattern of a character, zero for word spaces and unknown codes
    function automatic logic [SYM_W-1:0] code_lookup(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] idx;
        logic [SYM_W-1:0]  sym;
        idx = ch - CH_FIRST;
        sym = '0;
        if (ch >= CH_FIRST && ch <= CH_LAST) begin
            sym = CODE_ROM[idx[6:0]];
        end
        return sym;
    endfunction

    typedef struct packed {
        logic       load;
        logic       shift;
        logic       emit;
        logic       key_on;
        logic [1:0] dur_sel;
        logic       last;
        logic       done;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic has_elem;
        logic top_elem;
        logic final_char;
    } t_sts;

endpackage

/* design/morse_character_keyer_unit.sv */
// ---------------------------------------------------------------------------
// morse_character_keyer_unit
// turns text characters into timed morse key segments
// ---------------------------------------------------------------------------
//  port group   dir  payload
//  i_s_*        in   tdata[7:0] character, tlast final_char
//  o_m_*        out  tdata[0] key_on, tdata[16:1] duration_ms, tlast last_of_char,
//                    tuser text_done
//  i_cfg_*      in   register index and 16-bit value, taken on i_cfg_we
//
//  one character at a time: the accept, then for each element a scan step and
//  two segment steps (key on, then element gap), then the trailing gap; a final
//  character with elements ends on its last element gap, one without sends a
//  single zero-length segment. synchronous active-low reset restores the default
//  timings and empties the output register. a stalled output holds the sequencer
//  in place.
// ---------------------------------------------------------------------------
module morse_character_keyer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] character
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [0] key_on, [16:1] duration_ms, [23:17] zero
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // [0] text_done
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    mck_pkg::t_cmd cmd;
    mck_pkg::t_sts sts;

    logic                      key_on;
    logic [mck_pkg::DUR_W-1:0] duration;

    mck_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mck_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_char      (i_s_tdata),
        .i_final     (i_s_tlast),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_key_on    (key_on),
        .o_duration  (duration),
        .o_last      (o_m_tlast),
        .o_done      (o_m_tuser)
    );

    assign o_m_tdata = {7'd0, duration, key_on};

endmodule

/* design/mck_ctrl.sv */
// ---------------------------------------------------------------------------
// mck_ctrl
// sequencer: walks the element pairs of one character and orders segments
// ---------------------------------------------------------------------------
module mck_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  mck_pkg::t_sts i_sts,
    output mck_pkg::t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_ON   = 3'd2;
    localparam logic [2:0] ST_OFF  = 3'd3;
    localparam logic [2:0] ST_GAP  = 3'd4;
    localparam logic [2:0] ST_ZERO = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.dur_sel = mck_pkg::DUR_KEY;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // reached after the accept and after each element with more to follow; skips empty pairs
                if (i_sts.has_elem) begin
                    if (i_sts.top_elem) begin
                        n_state = ST_ON;
                    end else begin
                        o_cmd.shift = 1'b1;
                    end
                end else begin
                    n_state = i_sts.final_char ? ST_ZERO : ST_GAP;
                end
            end
            ST_ON: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.key_on  = 1'b1;
                    o_cmd.dur_sel = mck_pkg::DUR_KEY;
                    o_cmd.shift   = 1'b1;
                    n_state       = ST_OFF;
                end
            end
            ST_OFF: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.dur_sel = mck_pkg::DUR_EGAP;
                    // pattern already shifted: has_elem says more elements follow
                    if (i_sts.has_elem) begin
                        n_state = ST_SCAN;
                    end else if (i_sts.final_char) begin
                        o_cmd.last = 1'b1;
                        o_cmd.done = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_state = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.dur_sel = mck_pkg::DUR_GAP;
                    o_cmd.last    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_ZERO: begin
                if (i_sts.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.dur_sel = mck_pkg::DUR_ZERO;
                    o_cmd.last    = 1'b1;
                    o_cmd.done    = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* design/mck_dp.sv */
// ---------------------------------------------------------------------------
// mck_dp
// datapath: timing registers, element pattern shifter and output register
// ---------------------------------------------------------------------------
module mck_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mck_pkg::ADDR_W-1:0]    i_cfg_addr,
    input  logic [mck_pkg::DUR_W-1:0]     i_cfg_wdata,
    input  logic [mck_pkg::CHAR_W-1:0]    i_char,
    input  logic                          i_final,
    input  mck_pkg::t_cmd                 i_cmd,
    output mck_pkg::t_sts                 o_sts,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic                          o_key_on,
    output logic [mck_pkg::DUR_W-1:0]     o_duration,
    output logic                          o_last,
    output logic                          o_done
);

    logic [mck_pkg::DUR_W-1:0] r_dit;
    logic [mck_pkg::DUR_W-1:0] r_dah;
    logic [mck_pkg::DUR_W-1:0] r_egap;
    logic [mck_pkg::DUR_W-1:0] r_lgap;
    logic [mck_pkg::DUR_W-1:0] r_wgap;

    logic [mck_pkg::SYM_W-1:0] r_sym;
    logic                      r_final;
    logic                      r_word;
    logic                      r_valid;
    logic                      r_key_on;
    logic [mck_pkg::DUR_W-1:0] r_duration;
    logic                      r_last;
    logic                      r_done;

    logic [mck_pkg::DUR_W-1:0] total_gap;
    logic [mck_pkg::DUR_W-1:0] n_duration;
    logic                      char_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit  <= mck_pkg::RST_DIT;
            r_dah  <= mck_pkg::RST_DAH;
            r_egap <= mck_pkg::RST_ELEM_GAP;
            r_lgap <= mck_pkg::RST_LETTER_GAP;
            r_wgap <= mck_pkg::RST_WORD_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                mck_pkg::REG_DIT:        r_dit  <= i_cfg_wdata;
                mck_pkg::REG_DAH:        r_dah  <= i_cfg_wdata;
                mck_pkg::REG_ELEM_GAP:   r_egap <= i_cfg_wdata;
                mck_pkg::REG_LETTER_GAP: r_lgap <= i_cfg_wdata;
                mck_pkg::REG_WORD_GAP:   r_wgap <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign char_word = (i_char == mck_pkg::CH_TAB) || (i_char == mck_pkg::CH_CR) ||
                       (i_char == mck_pkg::CH_SPACE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sym   <= char_word ? '0 : mck_pkg::code_lookup(i_char);
            r_final <= i_final;
            r_word  <= char_word;
        end else if (i_cmd.shift) begin
            r_sym <= {r_sym[mck_pkg::SYM_W-3:0], 2'b00};
        end
    end

    // trailing gap is the word or letter gap less the element gap, floored at zero
    assign total_gap = r_word ? r_wgap : r_lgap;

    always_comb begin
        case (i_cmd.dur_sel)
            mck_pkg::DUR_KEY:  n_duration = r_sym[mck_pkg::SYM_W-1] ? r_dah : r_dit;
            mck_pkg::DUR_EGAP: n_duration = r_egap;
            mck_pkg::DUR_GAP:  n_duration = (total_gap > r_egap) ? total_gap - r_egap : '0;
            mck_pkg::DUR_ZERO: n_duration = '0;
            default:           n_duration = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_key_on   <= i_cmd.key_on;
            r_duration <= n_duration;
            r_last     <= i_cmd.last;
            r_done     <= i_cmd.done;
        end
    end

    assign o_sts.out_free   = !r_valid || i_m_tready;
    assign o_sts.has_elem   = |(r_sym & mck_pkg::ELEM_MASK);
    assign o_sts.top_elem   = r_sym[mck_pkg::SYM_W-2];
    assign o_sts.final_char = r_final;

    assign o_m_tvalid = r_valid;
    assign o_key_on   = r_key_on;
    assign o_duration = r_duration;
    assign o_last     = r_last;
    assign o_done     = r_done;

endmodule
